// File: rtl/core/group_points_into_lines_defines.svh
// Assertion macros used by the checker file.
`ifndef GROUP_POINTS_INTO_LINES_DEFINES_SVH
`define GROUP_POINTS_INTO_LINES_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GPIL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpil assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GPIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpil assertion failed");

`endif

// File: rtl/core/gpil_pkg.sv
// Shared constants and types for the point-to-line grouping block.
package gpil_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 14;
    localparam int THR_W          = 14;
    localparam int LINE_W         = 6;

    // one-hot step select for the shared multiply/compare unit
    typedef struct packed {
        logic mul_y;
        logic diff;
        logic mul_thr;
        logic cmp;
    } arith_ctl_t;

endpackage

// File: rtl/core/gpil_ram.sv
// Generic simple dual-port RAM with registered read.
module gpil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/gpil_arith.sv
// Shared multiply / subtract / compare unit for the new-line test.
// Steps: y*size, |sum - prod|, thr*size, diff > prod.
module gpil_arith #(
    parameter int MAX_POINTS = gpil_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = gpil_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  gpil_pkg::arith_ctl_t                            ctl,
    input  logic [COORD_BITS+$clog2(MAX_POINTS+1)-1:0]      sum,
    input  logic [COORD_BITS-1:0]                           y,
    input  logic [gpil_pkg::THR_W-1:0]                      thr,
    input  logic [$clog2(MAX_POINTS+1)-1:0]                 size,
    output logic                                            far
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int OP_W   = (COORD_BITS > gpil_pkg::THR_W) ? COORD_BITS : gpil_pkg::THR_W;
    localparam int PROD_W = OP_W + CNT_W;

    logic [OP_W-1:0]   mul_a;
    logic [PROD_W-1:0] prod_full;
    logic [PROD_W:0]   sub;
    logic [PROD_W:0]   sub_abs;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] diff_reg;
    logic              far_reg;

    assign mul_a     = ctl.mul_thr ? OP_W'(thr) : OP_W'(y);
    assign prod_full = PROD_W'(mul_a) * PROD_W'(size);
    assign sub       = {1'b0, PROD_W'(sum)} - {1'b0, prod_reg};
    assign sub_abs   = sub[PROD_W] ? (~sub + 1'b1) : sub;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_y || ctl.mul_thr)
        begin
            prod_reg <= prod_full;
        end
        if (ctl.diff)
        begin
            diff_reg <= sub_abs[PROD_W-1:0];
        end
        if (ctl.cmp)
        begin
            far_reg <= (diff_reg > prod_reg);
        end
    end

    assign far = far_reg;

endmodule

// File: rtl/core/group_points_into_lines.sv
// Top level: groups box centers into text lines and emits them at page end.
// Per center: into an empty line it is written directly, and on a full page it is dropped;
// otherwise the shared unit checks whether it opens a new line, then it is written in x order,
// either at the line front or behind a stored point, with each stored point of larger x shifted
// right in the point RAM. Emission reads, loads and offers each word, plus a line-start RAM
// read per closed line. Reset clears page state and threshold; the RAMs are not cleared.
module group_points_into_lines #(
    parameter int MAX_POINTS = gpil_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = gpil_pkg::COORD_BITS_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  cfg_wr_en,
    input  logic [gpil_pkg::THR_W-1:0]                            cfg_wr_data,  // line_threshold
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // s_tdata: point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]                     s_tdata,
    input  logic                                                  s_tlast,      // page_end
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // m_tdata: out_x, out_y, line_number
    output logic [((2*COORD_BITS+gpil_pkg::LINE_W+7)/8)*8-1:0]    m_tdata,
    output logic                                                  m_tuser,      // line_end
    output logic                                                  m_tlast       // page_done
);

    localparam int OUT_W = ((2*COORD_BITS + gpil_pkg::LINE_W + 7) / 8) * 8;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int SUM_W = COORD_BITS + CNT_W;
    localparam int PT_W  = 2 * COORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_Y,
        ST_DIFF,
        ST_MUL_T,
        ST_CMP,
        ST_SPLIT,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_WR,
        ST_EM_RD,
        ST_EM_LOAD,
        ST_EM_OUT,
        ST_EM_LS
    } state_t;

    state_t                        state_reg, state_next;
    logic [gpil_pkg::THR_W-1:0]    thr_reg;
    logic [COORD_BITS-1:0]         x_reg, x_next;
    logic [COORD_BITS-1:0]         y_reg, y_next;
    logic                          last_reg, last_next;
    logic [CNT_W-1:0]              held_reg, held_next;
    logic [IDX_W-1:0]              closed_reg, closed_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]              size_reg, size_next;
    logic [IDX_W-1:0]              start_reg, start_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic [IDX_W-1:0]              i_reg, i_next;
    logic [IDX_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;
    logic [IDX_W-1:0]              left_reg, left_next;
    logic [gpil_pkg::LINE_W-1:0]   line_no_reg, line_no_next;
    logic                          m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0]         ox_reg, ox_next;
    logic [COORD_BITS-1:0]         oy_reg, oy_next;
    logic [gpil_pkg::LINE_W-1:0]   oline_reg, oline_next;
    logic                          oend_reg, oend_next;
    logic                          odone_reg, odone_next;

    logic                          pt_wr_en;
    logic [IDX_W-1:0]              pt_wr_addr;
    logic [PT_W-1:0]               pt_wr_data;
    logic                          pt_rd_en;
    logic [IDX_W-1:0]              pt_rd_addr;
    logic [PT_W-1:0]               pt_rd_data;
    logic                          ls_wr_en;
    logic                          ls_rd_en;
    logic [IDX_W-1:0]              ls_rd_addr;
    logic [IDX_W-1:0]              ls_rd_data;

    gpil_pkg::arith_ctl_t          actl;
    logic                          far;
    logic                          s_acc;
    logic [IDX_W-1:0]              pos_dec;
    logic [CNT_W-1:0]              held_inc;

    assign s_acc    = s_tvalid && s_tready;
    assign pos_dec  = pos_reg - IDX_W'(1);
    assign held_inc = held_reg + CNT_W'(1);

    assign actl.mul_y   = (state_reg == ST_MUL_Y);
    assign actl.diff    = (state_reg == ST_DIFF);
    assign actl.mul_thr = (state_reg == ST_MUL_T);
    assign actl.cmp     = (state_reg == ST_CMP);

    gpil_arith #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_arith (
        .clk  (clk),
        .ctl  (actl),
        .sum  (sum_reg),
        .y    (y_reg),
        .thr  (thr_reg),
        .size (size_reg),
        .far  (far)
    );

    // points, stored line after line, each line sorted by x: {y, x}
    gpil_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_pt_ram (
        .clk     (clk),
        .wr_en   (pt_wr_en),
        .wr_addr (pt_wr_addr),
        .wr_data (pt_wr_data),
        .rd_en   (pt_rd_en),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    // first index of each closed line
    gpil_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_POINTS)
    ) u_ls_ram (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (closed_reg),
        .wr_data (start_reg),
        .rd_en   (ls_rd_en),
        .rd_addr (ls_rd_addr),
        .rd_data (ls_rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        last_next    = last_reg;
        held_next    = held_reg;
        closed_next  = closed_reg;
        sum_next     = sum_reg;
        size_next    = size_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        i_next       = i_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        left_next    = left_reg;
        line_no_next = line_no_reg;
        m_valid_next = m_valid_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oline_next   = oline_reg;
        oend_next    = oend_reg;
        odone_next   = odone_reg;
        pt_wr_en     = 1'b0;
        pt_wr_addr   = pos_reg;
        pt_wr_data   = {y_reg, x_reg};
        pt_rd_en     = 1'b0;
        pt_rd_addr   = pos_dec;
        ls_wr_en     = 1'b0;
        ls_rd_en     = 1'b0;
        ls_rd_addr   = left_reg - IDX_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    x_next    = s_tdata[COORD_BITS-1:0];
                    y_next    = s_tdata[2*COORD_BITS-1:COORD_BITS];
                    last_next = s_tlast;
                    pos_next  = held_reg[IDX_W-1:0];
                    if (held_reg == CNT_W'(MAX_POINTS))
                    begin
                        // page full: word dropped, still emit on page end
                        if (s_tlast)
                        begin
                            i_next       = start_reg;
                            lo_next      = start_reg;
                            hi_next      = held_reg;
                            left_next    = closed_reg;
                            line_no_next = '0;
                            state_next   = ST_EM_RD;
                        end
                    end
                    else if (size_reg != '0)
                    begin
                        state_next = ST_MUL_Y;
                    end
                    else
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_MUL_Y: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL_T;
            ST_MUL_T: state_next = ST_CMP;
            ST_CMP:   state_next = ST_SPLIT;
            ST_SPLIT:
            begin
                if (far)
                begin
                    ls_wr_en    = 1'b1;
                    closed_next = closed_reg + IDX_W'(1);
                    start_next  = held_reg[IDX_W-1:0];
                    size_next   = '0;
                    sum_next    = '0;
                end
                state_next = ST_INS_RD;
            end
            ST_INS_RD:
            begin
                if (pos_reg > start_reg)
                begin
                    pt_rd_en   = 1'b1;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_CHK:
            begin
                // read data holds the point at pos - 1
                if (pt_rd_data[COORD_BITS-1:0] > x_reg)
                begin
                    pt_wr_en   = 1'b1;
                    pt_wr_data = pt_rd_data;
                    pos_next   = pos_dec;
                    if (pos_dec > start_reg)
                    begin
                        pt_rd_en   = 1'b1;
                        pt_rd_addr = pos_dec - IDX_W'(1);
                    end
                    else
                    begin
                        state_next = ST_INS_WR;
                    end
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                pt_wr_en  = 1'b1;
                held_next = held_inc;
                size_next = size_reg + CNT_W'(1);
                sum_next  = sum_reg + SUM_W'(y_reg);
                if (last_reg)
                begin
                    i_next       = start_reg;
                    lo_next      = start_reg;
                    hi_next      = held_inc;
                    left_next    = closed_reg;
                    line_no_next = '0;
                    state_next   = ST_EM_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EM_RD:
            begin
                pt_rd_en   = 1'b1;
                pt_rd_addr = i_reg;
                state_next = ST_EM_LOAD;
            end
            ST_EM_LOAD:
            begin
                ox_next      = pt_rd_data[COORD_BITS-1:0];
                oy_next      = pt_rd_data[PT_W-1:COORD_BITS];
                oline_next   = line_no_reg;
                oend_next    = (CNT_W'(i_reg) + CNT_W'(1) == hi_reg);
                odone_next   = (CNT_W'(i_reg) + CNT_W'(1) == hi_reg) && (left_reg == '0);
                m_valid_next = 1'b1;
                state_next   = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                if (m_tready)
                begin
                    m_valid_next = 1'b0;
                    if (!oend_reg)
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_EM_RD;
                    end
                    else if (left_reg == '0)
                    begin
                        held_next   = '0;
                        closed_next = '0;
                        sum_next    = '0;
                        size_next   = '0;
                        start_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        ls_rd_en     = 1'b1;
                        hi_next      = CNT_W'(lo_reg);
                        left_next    = left_reg - IDX_W'(1);
                        line_no_next = line_no_reg + gpil_pkg::LINE_W'(1);
                        state_next   = ST_EM_LS;
                    end
                end
            end
            ST_EM_LS:
            begin
                lo_next    = ls_rd_data;
                i_next     = ls_rd_data;
                state_next = ST_EM_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            held_reg    <= '0;
            closed_reg  <= '0;
            sum_reg     <= '0;
            size_reg    <= '0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            closed_reg  <= closed_next;
            sum_reg     <= sum_next;
            size_reg    <= size_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        last_reg    <= last_next;
        pos_reg     <= pos_next;
        i_reg       <= i_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        left_reg    <= left_next;
        line_no_reg <= line_no_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        oline_reg   <= oline_next;
        oend_reg    <= oend_next;
        odone_reg   <= odone_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({oline_reg, oy_reg, ox_reg});
    assign m_tuser  = oend_reg;
    assign m_tlast  = odone_reg;

endmodule

// File: rtl/core/gpil_checker.sv
// Port-level checker for the line grouping block, bound to the top level.
`include "group_points_into_lines_defines.svh"

module gpil_checker #(
    parameter int OUT_W = 40
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    logic in_word;
    logic out_word;

    assign in_word  = s_tvalid && s_tready;
    assign out_word = m_tvalid && m_tready;

    // one word at a time: no intake while a result is pending
    `GPIL_ASSERT_NOW(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)
    // page end is always also a line end
    `GPIL_ASSERT_NOW(a_done_ends_line, clk, rst_n, m_tvalid && m_tlast, m_tuser)
    // after the final word of a page the block takes input again
    `GPIL_ASSERT_NEXT(a_ready_after_page, clk, rst_n, out_word && m_tlast, s_tready && !m_tvalid)
    // a word taken without page end gives no result next cycle
    `GPIL_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_word && !s_tlast, !m_tvalid)
    // a stalled result word holds until taken
    `GPIL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind group_points_into_lines gpil_checker #(
    .OUT_W (OUT_W)
) u_gpil_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
